FILE: rtl/blocked_welford_mean_variance_defines.svh
// Assertion macros shared by the RTL of the blocked Welford statistics block.
// Define ASSERT_OFF to compile the checks away; no other dependencies.
`ifndef BLOCKED_WELFORD_MEAN_VARIANCE_DEFINES_SVH
`define BLOCKED_WELFORD_MEAN_VARIANCE_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication on clk, disabled while rst is high.
`define BWMV_ASSERT_IMPL(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("%m: check failed");
// Next-cycle implication on clk, disabled while rst is high.
`define BWMV_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("%m: check failed");
`else
`define BWMV_ASSERT_IMPL(label, cond, expr)
`define BWMV_ASSERT_NEXT(label, cond, expr)
`endif

`endif

FILE: rtl/bwmv_pkg.sv
// Shared constants, codes, types and helper functions of the blocked Welford block.
// Used by the divider, the multiplier and the top level; no dependencies.
package bwmv_pkg;

  localparam int NUM_GENES   = 4096;
  localparam int NUM_BLOCKS  = 16;
  localparam int STORE_DEPTH = NUM_GENES * NUM_BLOCKS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int BLK_W       = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  localparam int MEAN_W = 48;
  localparam int SSQ_W  = 64;
  localparam int CNT_W  = 32;
  localparam int WORD_W = MEAN_W + SSQ_W + CNT_W;

  localparam int DIV_W     = 96;
  localparam int DIVISOR_W = 32;
  localparam int STEP_W    = 7;
  localparam int MUL_PARTS = 4;

  // Item modes.
  localparam logic [1:0] MODE_VALUE    = 2'd0;
  localparam logic [1:0] MODE_END_CELL = 2'd1;
  localparam logic [1:0] MODE_REPORT   = 2'd2;

  // Transform modes.
  localparam logic [1:0] TM_RAW = 2'd0;
  localparam logic [1:0] TM_DIV = 2'd1;
  localparam logic [1:0] TM_LOG = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_TRANSFORM_MODE = 1'b0;
  localparam logic CFG_PSEUDO_COUNT   = 1'b1;

  localparam logic [31:0]       PSEUDO_ONE = 32'h0001_0000;
  localparam logic [MEAN_W-1:0] MEAN_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic [MEAN_W-1:0] MEAN_MIN   = 48'h8000_0000_0000;
  localparam logic [62:0]       VAR_MAX    = '1;

  typedef struct packed {
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
    logic [STEP_W-1:0]    steps;
  } div_req_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // floor(p / 2^32), saturating at the 64-bit maximum.
  function automatic logic [63:0] shr32_sat(input logic [127:0] p);
    return (p[127:96] != 32'd0) ? '1 : p[95:32];
  endfunction

endpackage

FILE: rtl/bwmv_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module bwmv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bwmv_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on bwmv_pkg for the request and status types.
module bwmv_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  bwmv_pkg::div_req_t           req,
  output bwmv_pkg::unit_sts_t          sts,
  output logic [bwmv_pkg::DIV_W-1:0]   quo
);
  import bwmv_pkg::*;

  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W-1:0] rem;
  logic [STEP_W-1:0]    cnt;
  logic                 busy;
  logic                 done;
  logic [DIVISOR_W:0]   shifted;
  logic                 ge;

  // The dividend sits left aligned in quo; its bits shift out at the top while
  // quotient bits enter at the bottom.
  assign shifted = {rem, quo[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dvs};
  assign sts     = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // The done pulse lasts one cycle; the divider is idle while it is high.
      if (done) begin
        done <= 1'b0;
      end
      if (start) begin
        busy <= 1'b1;
        quo  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
        cnt  <= req.steps;
      end else if (busy) begin
        rem <= ge ? DIVISOR_W'(shifted - {1'b0, dvs}) : shifted[DIVISOR_W-1:0];
        quo <= {quo[DIV_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/bwmv_mul.sv
// 64 by 64 multiplier built from four 32 by 32 partial products over cycles.
// Depends on bwmv_pkg for the request and status types.
module bwmv_mul (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  bwmv_pkg::mul_req_t  req,
  output bwmv_pkg::unit_sts_t sts,
  output logic [127:0]        prod
);
  import bwmv_pkg::*;

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [2:0]   cnt;
  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic         pp_vld;
  logic         busy;
  logic         done;
  logic [31:0]  a_part;
  logic [31:0]  b_part;
  logic [127:0] pp_add;

  assign a_part = cnt[1] ? a_r[63:32] : a_r[31:0];
  assign b_part = cnt[0] ? b_r[63:32] : b_r[31:0];
  assign sts    = '{busy: busy, done: done};

  always_comb begin
    case (pp_sh)
      2'd0:    pp_add = {64'd0, pp};
      2'd1:    pp_add = {32'd0, pp, 32'd0};
      default: pp_add = {pp, 64'd0};
    endcase
  end

  // One partial product is registered per cycle and added the cycle after.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      pp_vld <= 1'b0;
    end else begin
      // The done pulse lasts one cycle; the multiplier is idle while it is high.
      if (done) begin
        done <= 1'b0;
      end
      if (start) begin
        a_r    <= req.a;
        b_r    <= req.b;
        prod   <= '0;
        cnt    <= '0;
        busy   <= 1'b1;
        pp_vld <= 1'b0;
      end else if (busy) begin
        if (cnt != 3'(MUL_PARTS)) begin
          pp     <= {32'd0, a_part} * {32'd0, b_part};
          pp_sh  <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
          pp_vld <= 1'b1;
          cnt    <= cnt + 1'b1;
        end else begin
          pp_vld <= 1'b0;
        end
        if (pp_vld) begin
          prod <= prod + pp_add;
        end
        if (cnt == 3'(MUL_PARTS) && pp_vld) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/blocked_welford_mean_variance.sv
// Blocked Welford mean/variance: one item at a time. A value item may first pass through
// the divide or the log2 transform; a report uses the shared bit-serial divider (one bit
// per cycle) and the partial-product multiplier. After a synchronous reset a clearing
// pass zeroes the 65536 statistics memory entries; items are held off during it,
// configuration writes are taken.
`include "blocked_welford_mean_variance_defines.svh"

module blocked_welford_mean_variance (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         mode,
  input  logic [11:0]        gene_index,
  input  logic [3:0]         block_index,
  input  logic               block_missing,
  input  logic [31:0]        raw_value,
  input  logic [23:0]        size_factor,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [47:0] mean_value,
  output logic [62:0]        variance_value,
  output logic               mean_valid,
  output logic               variance_valid
);
  import bwmv_pkg::*;

  // The sequencer walks one transaction through the transform, the memory
  // read, and either the Welford update with its write back or the report arithmetic.
  // Only one transaction is in flight, so a read never overlaps a pending
  // write of the same entry and no forwarding is needed.
  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_QDIV, S_QDONE, S_LNORM, S_LSQ, S_ZCHK,
    S_URD, S_UDIV, S_UD2, S_UMUL, S_UWR,
    S_RRD, S_R1, S_R2, S_R3, S_R4, S_R5, S_R6, S_RVAR, S_R7, S_OUT
  } state_t;

  state_t st;

  // Configuration registers.
  logic [1:0]  transform_mode;
  logic [31:0] pseudo_count;

  // Cells counted per block.
  logic [CNT_W-1:0] cells [NUM_BLOCKS];

  // Latched transaction.
  logic [1:0]       op_mode;
  logic [ADDR_W-1:0] addr_r;
  logic [BLK_W-1:0] blk_r;
  logic             missing_r;
  logic             in_range_r;
  logic             blk_ok_r;
  logic [31:0]      raw_r;
  logic [23:0]      sf_r;

  // Working registers.
  logic [ADDR_W-1:0] clr_addr;
  logic [MEAN_W-1:0] x;
  logic [63:0]       qv;
  logic [63:0]       ytmp;
  logic [5:0]        kexp;
  logic [31:0]       lm;
  logic [31:0]       frac;
  logic [4:0]        iter;
  logic [MEAN_W-1:0] cur_mean;
  logic [SSQ_W-1:0]  cur_ssq;
  logic [CNT_W-1:0]  cur_cnt;
  logic              delta_neg;
  logic [48:0]       delta_mag;
  logic [MEAN_W-1:0] new_mean;
  logic [SSQ_W-1:0]  ssq_inc;
  logic [CNT_W-1:0]  cnt_c;
  logic [CNT_W-1:0]  cnt_z;
  logic [MEAN_W-1:0] res_mean;
  logic [62:0]       res_var;
  logic              res_mv;
  logic              res_vv;

  // Arithmetic units.
  logic          div_start;
  div_req_t      div_req;
  unit_sts_t     div_sts;
  logic [DIV_W-1:0] div_quo;
  logic          mul_start;
  mul_req_t      mul_req;
  unit_sts_t     mul_sts;
  logic [127:0]  mul_prod;

  // Statistics memory.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  // Combinational helpers.
  logic [MEAN_W-1:0] rd_mean;
  logic [SSQ_W-1:0]  rd_ssq;
  logic [CNT_W-1:0]  rd_cnt;
  logic [48:0]       delta_full;
  logic [48:0]       delta_abs;
  logic [CNT_W-1:0]  n_new;
  logic [48:0]       q49;
  logic [49:0]       mean_step;
  logic [49:0]       mean_sum;
  logic [48:0]       d2_full;
  logic [48:0]       d2_abs;
  logic [MEAN_W-1:0] rd_mag;
  logic [MEAN_W-1:0] cur_mag;
  logic [CNT_W-1:0]  z_clamp;
  logic              preserved;
  logic              q_sat;
  logic [63:0]       v_log;
  logic [63:0]       sq;
  logic [32:0]       sq_top;
  logic [31:0]       lm_next;
  logic [31:0]       frac_next;
  logic [6:0]        k_signed;
  logic [MEAN_W-1:0] log_x;
  logic [SSQ_W-1:0]  ssq_new;
  logic [MEAN_W-1:0] scaled_mag;

  bwmv_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_stats_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  bwmv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .sts   (div_sts),
    .quo   (div_quo)
  );

  bwmv_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .req   (mul_req),
    .sts   (mul_sts),
    .prod  (mul_prod)
  );

  assign item_stall = (st != S_IDLE);

  always_comb begin
    rd_mean = ram_rdata[WORD_W-1 -: MEAN_W];
    rd_ssq  = ram_rdata[CNT_W +: SSQ_W];
    rd_cnt  = ram_rdata[CNT_W-1:0];

    // Welford step: delta against the stored mean, count saturates.
    delta_full = {x[MEAN_W-1], x} - {rd_mean[MEAN_W-1], rd_mean};
    delta_abs  = delta_full[48] ? (49'd0 - delta_full) : delta_full;
    n_new      = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;

    // The divider returns |delta|/n; the sign comes back here, so the step
    // truncates toward zero.
    q49       = div_quo[48:0];
    mean_step = delta_neg ? (50'd0 - {1'b0, q49}) : {1'b0, q49};
    mean_sum  = {{2{cur_mean[MEAN_W-1]}}, cur_mean} + mean_step;
    d2_full   = {x[MEAN_W-1], x} - {new_mean[MEAN_W-1], new_mean};
    d2_abs    = d2_full[48] ? (49'd0 - d2_full) : d2_full;

    rd_mag  = rd_mean[MEAN_W-1] ? (48'd0 - rd_mean) : rd_mean;
    cur_mag = cur_mean[MEAN_W-1] ? (48'd0 - cur_mean) : cur_mean;
    z_clamp = (rd_cnt > cnt_c) ? cnt_c : rd_cnt;

    preserved = (transform_mode != TM_LOG) || (pseudo_count == PSEUDO_ONE);

    // The Q32.32 quotient overflows when raw reaches sf * 2^24.
    q_sat = (sf_r == 24'd0) || ({16'd0, raw_r} >= {sf_r, 24'd0});
    v_log = sat_add64(qv, {16'd0, pseudo_count, 16'd0});

    // One fraction bit of log2 per squaring of the normalized mantissa.
    sq        = {32'd0, lm} * {32'd0, lm};
    sq_top    = sq[63:31];
    lm_next   = sq_top[32] ? sq_top[32:1] : sq_top[31:0];
    frac_next = {frac[30:0], sq_top[32]};
    k_signed  = {1'b0, kexp} - 7'd32;
    log_x     = {{9{k_signed[6]}}, k_signed, frac_next};

    ssq_new    = sat_add64(cur_ssq, ssq_inc);
    scaled_mag = div_quo[MEAN_W-1:0];

    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = {new_mean, ssq_new, cur_cnt};
    if (st == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (st == S_UWR) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= S_CLEAR;
      clr_addr       <= '0;
      transform_mode <= TM_RAW;
      pseudo_count   <= PSEUDO_ONE;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        cells[i] <= '0;
      end
      result_valid   <= 1'b0;
      div_start      <= 1'b0;
      mul_start      <= 1'b0;
    end else begin
      // Start pulses last one cycle; no unit is launched in the cycle after
      // a launch of the same unit.
      if (div_start) begin
        div_start <= 1'b0;
      end
      if (mul_start) begin
        mul_start <= 1'b0;
      end

      // Configuration writes are taken at once; the sender must only issue them
      // while no transaction is in flight, which the block itself does not enforce.
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_TRANSFORM_MODE: transform_mode <= cfg_data[1:0];
          CFG_PSEUDO_COUNT:   pseudo_count   <= cfg_data;
          default: ;
        endcase
      end

      // In S_OUT the result register is reloaded instead.
      if (result_valid && !result_stall && st != S_OUT) begin
        result_valid <= 1'b0;
      end

      unique case (st)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
            st <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (item_valid) begin
            op_mode    <= mode;
            addr_r     <= ADDR_W'(32'(gene_index) * NUM_BLOCKS + 32'(block_index));
            blk_r      <= block_index[BLK_W-1:0];
            missing_r  <= block_missing;
            in_range_r <= (32'(gene_index) < NUM_GENES) && (32'(block_index) < NUM_BLOCKS);
            blk_ok_r   <= (32'(block_index) < NUM_BLOCKS);
            raw_r      <= raw_value;
            sf_r       <= size_factor;
            st         <= S_DISPATCH;
          end
        end

        S_DISPATCH: begin
          unique case (op_mode)
            MODE_VALUE: begin
              if (missing_r || !in_range_r) begin
                st <= S_IDLE;
              end else if (transform_mode == TM_DIV || transform_mode == TM_LOG) begin
                if (q_sat) begin
                  qv <= '1;
                  st <= S_QDONE;
                end else begin
                  // raw * 2^40 / sf, dividend left aligned over 72 steps.
                  div_req   <= '{dividend: {raw_r, 64'd0}, divisor: {8'd0, sf_r},
                                 steps: STEP_W'(72)};
                  div_start <= 1'b1;
                  st        <= S_QDIV;
                end
              end else begin
                x  <= (raw_r >= 32'h0080_0000) ? MEAN_MAX : {1'b0, raw_r[22:0], 24'd0};
                st <= S_ZCHK;
              end
            end
            MODE_END_CELL: begin
              if (!missing_r && blk_ok_r && cells[blk_r] != '1) begin
                cells[blk_r] <= cells[blk_r] + 1'b1;
              end
              st <= S_IDLE;
            end
            MODE_REPORT: begin
              res_mean <= '0;
              res_var  <= '0;
              res_mv   <= 1'b0;
              res_vv   <= 1'b0;
              if (!in_range_r || cells[blk_r] == '0) begin
                st <= S_OUT;
              end else begin
                cnt_c <= cells[blk_r];
                st    <= S_RRD;
              end
            end
            default: st <= S_IDLE;
          endcase
        end

        S_QDIV: begin
          if (div_sts.done) begin
            qv <= div_quo[63:0];
            st <= S_QDONE;
          end
        end

        S_QDONE: begin
          if (transform_mode == TM_DIV) begin
            x  <= (qv > {16'd0, MEAN_MAX}) ? MEAN_MAX : qv[MEAN_W-1:0];
            st <= S_ZCHK;
          end else if (v_log == 64'd0) begin
            x  <= MEAN_MIN;
            st <= S_ZCHK;
          end else begin
            ytmp <= v_log;
            kexp <= 6'd63;
            st   <= S_LNORM;
          end
        end

        S_LNORM: begin
          if (ytmp[63]) begin
            lm   <= ytmp[63:32];
            frac <= '0;
            iter <= '0;
            st   <= S_LSQ;
          end else begin
            ytmp <= {ytmp[62:0], 1'b0};
            kexp <= kexp - 1'b1;
          end
        end

        S_LSQ: begin
          lm   <= lm_next;
          frac <= frac_next;
          iter <= iter + 1'b1;
          if (iter == '1) begin
            x  <= log_x;
            st <= S_ZCHK;
          end
        end

        S_ZCHK: begin
          st <= (preserved && x == '0) ? S_IDLE : S_URD;
        end

        S_URD: begin
          cur_mean  <= rd_mean;
          cur_ssq   <= rd_ssq;
          cur_cnt   <= n_new;
          delta_neg <= delta_full[48];
          delta_mag <= delta_abs;
          div_req   <= '{dividend: {delta_abs, 47'd0}, divisor: n_new, steps: STEP_W'(49)};
          div_start <= 1'b1;
          st        <= S_UDIV;
        end

        S_UDIV: begin
          if (div_sts.done) begin
            new_mean <= mean_sum[MEAN_W-1:0];
            st       <= S_UD2;
          end
        end

        S_UD2: begin
          mul_req   <= '{a: {15'd0, delta_mag}, b: {15'd0, d2_abs}};
          mul_start <= 1'b1;
          st        <= S_UMUL;
        end

        S_UMUL: begin
          if (mul_sts.done) begin
            ssq_inc <= shr32_sat(mul_prod);
            st      <= S_UWR;
          end
        end

        S_UWR: begin
          st <= S_IDLE;
        end

        S_RRD: begin
          cur_mean <= rd_mean;
          cur_ssq  <= rd_ssq;
          cnt_z    <= z_clamp;
          res_mean <= rd_mean;
          if (preserved) begin
            mul_req   <= '{a: {16'd0, rd_mag}, b: {16'd0, rd_mag}};
            mul_start <= 1'b1;
            st        <= S_R1;
          end else begin
            st <= S_RVAR;
          end
        end

        // Zero correction: t = floor(M^2 z / c), ssq += t (c - z).
        S_R1: begin
          if (mul_sts.done) begin
            mul_req   <= '{a: shr32_sat(mul_prod), b: {32'd0, cnt_z}};
            mul_start <= 1'b1;
            st        <= S_R2;
          end
        end

        S_R2: begin
          if (mul_sts.done) begin
            div_req   <= '{dividend: mul_prod[DIV_W-1:0], divisor: cnt_c,
                           steps: STEP_W'(DIV_W)};
            div_start <= 1'b1;
            st        <= S_R3;
          end
        end

        S_R3: begin
          if (div_sts.done) begin
            mul_req   <= '{a: div_quo[63:0], b: {32'd0, cnt_c - cnt_z}};
            mul_start <= 1'b1;
            st        <= S_R4;
          end
        end

        S_R4: begin
          if (mul_sts.done) begin
            cur_ssq   <= (mul_prod[127:64] != 64'd0) ? '1 :
                         sat_add64(cur_ssq, mul_prod[63:0]);
            mul_req   <= '{a: {16'd0, cur_mag}, b: {32'd0, cnt_z}};
            mul_start <= 1'b1;
            st        <= S_R5;
          end
        end

        // Mean scaled by z / c, truncated toward zero.
        S_R5: begin
          if (mul_sts.done) begin
            div_req   <= '{dividend: mul_prod[DIV_W-1:0], divisor: cnt_c,
                           steps: STEP_W'(DIV_W)};
            div_start <= 1'b1;
            st        <= S_R6;
          end
        end

        S_R6: begin
          if (div_sts.done) begin
            res_mean <= cur_mean[MEAN_W-1] ? (48'd0 - scaled_mag) : scaled_mag;
            st       <= S_RVAR;
          end
        end

        S_RVAR: begin
          res_mv <= 1'b1;
          if (cnt_c > 32'd1) begin
            div_req   <= '{dividend: {cur_ssq, 32'd0}, divisor: cnt_c - 1'b1,
                           steps: STEP_W'(64)};
            div_start <= 1'b1;
            st        <= S_R7;
          end else begin
            res_var <= '0;
            res_vv  <= 1'b0;
            st      <= S_OUT;
          end
        end

        S_R7: begin
          if (div_sts.done) begin
            res_var <= div_quo[63] ? VAR_MAX : div_quo[62:0];
            res_vv  <= 1'b1;
            st      <= S_OUT;
          end
        end

        // The result register is loaded once the previous result has left.
        S_OUT: begin
          if (!result_valid || !result_stall) begin
            result_valid   <= 1'b1;
            mean_value     <= res_mean;
            variance_value <= res_var;
            mean_valid     <= res_mv;
            variance_valid <= res_vv;
            st             <= S_IDLE;
          end
        end

        default: st <= S_IDLE;
      endcase
    end
  end

  // A transaction is worked on alone: the input stalls once an item is taken.
  `BWMV_ASSERT_NEXT(a_one_in_flight, item_valid && !item_stall, item_stall)
  // The divider and the multiplier are never busy together.
  `BWMV_ASSERT_IMPL(a_units_exclusive, div_sts.busy, !mul_sts.busy)
  // A valid variance always comes with a valid mean.
  `BWMV_ASSERT_IMPL(a_var_needs_mean, result_valid, mean_valid || !variance_valid)

endmodule

FILE: verif/tb_blocked_welford_mean_variance.sv
// Self-checking testbench of the blocked Welford mean/variance block.
// Depends on bwmv_pkg and the RTL top blocked_welford_mean_variance only.
`timescale 1ns / 1ps

module tb_blocked_welford_mean_variance;
  import bwmv_pkg::*;

  // One input transaction, as driven on the item channel.
  typedef struct {
    bit [1:0]  mode;
    bit [11:0] gene;
    bit [3:0]  blk;
    bit        missing;
    bit [31:0] raw;
    bit [23:0] sf;
  } entry_t;

  // Expected report of one gene and block.
  typedef struct {
    bit [47:0] mean;
    bit [62:0] variance;
    bit        mean_ok;
    bit        variance_ok;
  } stats_t;

  // Scoreboard: keeps its own copy of the statistics store and of the two
  // configuration registers, predicts each report and checks the results.
  class welford_scoreboard;
    bit [1:0]    tmode;
    bit [31:0]   pseudo;
    longint      mean_tab[STORE_DEPTH];
    bit [63:0]   ssq_tab[STORE_DEPTH];
    int unsigned nz_tab[STORE_DEPTH];
    int unsigned cells[NUM_BLOCKS];
    stats_t      pending_reports[$];
    int          errors;

    function new();
      tmode  = TM_RAW;
      pseudo = PSEUDO_ONE;
      errors = 0;
    endfunction

    function void write_config(bit idx, bit [31:0] data);
      if (idx == CFG_TRANSFORM_MODE) tmode = data[1:0];
      else pseudo = data;
    endfunction

    function bit [63:0] add_sat(bit [63:0] a, bit [63:0] b);
      bit [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
    endfunction

    // floor(a*b / 2^32), saturating.
    function bit [63:0] mul_floor32(bit [63:0] a, bit [63:0] b);
      bit [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return (p[127:96] != 0) ? '1 : p[95:32];
    endfunction

    // floor(v*num/den) with num <= den.
    function bit [63:0] scale(bit [63:0] v, bit [63:0] num, bit [63:0] den);
      bit [127:0] p;
      p = ({64'd0, v} * {64'd0, num}) / {64'd0, den};
      return p[63:0];
    endfunction

    function bit [63:0] magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // Raw Q24.8 over size factor Q8.16, as unsigned Q32.32.
    function bit [63:0] ratio_q32(bit [31:0] raw, bit [23:0] sf);
      bit [127:0] q;
      if (sf == 0) return '1;
      q = {56'd0, raw, 40'd0} / {104'd0, sf};
      return (q[127:64] != 0) ? '1 : q[63:0];
    endfunction

    // log2 of a nonzero Q32.32 value, bit-serial by repeated squaring.
    function longint log2_fixed(bit [63:0] y);
      int k;
      bit [63:0] m;
      bit [63:0] frac;
      k = 63;
      frac = 0;
      while (k > 0 && !y[k]) k--;
      if (k >= 31) m = y >> (k - 31);
      else m = y << (31 - k);
      for (int i = 0; i < 32; i++) begin
        m = (m * m) >> 31;
        frac = frac << 1;
        if (m[32]) begin
          frac[0] = 1'b1;
          m = m >> 1;
        end
      end
      return longint'(k - 32) * 64'sd4294967296 + longint'(frac);
    endfunction

    function bit keeps_zeros();
      return tmode != TM_LOG || pseudo == PSEUDO_ONE;
    endfunction

    function longint transformed(bit [31:0] raw, bit [23:0] sf);
      bit [63:0] v;
      if (tmode == TM_DIV) begin
        v = ratio_q32(raw, sf);
        return (v > 64'h7FFF_FFFF_FFFF) ? 64'sh7FFF_FFFF_FFFF : longint'(v);
      end
      if (tmode == TM_LOG) begin
        v = add_sat(ratio_q32(raw, sf), {16'd0, pseudo, 16'd0});
        if (v == 0) return -64'sh8000_0000_0000;
        return log2_fixed(v);
      end
      if (raw >= 32'h0080_0000) return 64'sh7FFF_FFFF_FFFF;
      return longint'({raw, 24'd0});
    endfunction

    // Notes one accepted transaction: updates the store, counts a cell or queues a report.
    function void note_item(entry_t e);
      int idx;
      longint x, m, delta, mn, d2;
      int unsigned n;
      bit [63:0] c, z, s, t, mg;
      bit [127:0] p;
      stats_t r;
      idx = int'(e.gene) * NUM_BLOCKS + int'(e.blk);
      case (e.mode)
        MODE_VALUE: begin
          if (e.missing) return;
          x = transformed(e.raw, e.sf);
          if (keeps_zeros() && x == 0) return;
          n = nz_tab[idx];
          if (n != 32'hFFFF_FFFF) n++;
          nz_tab[idx] = n;
          m = mean_tab[idx];
          delta = x - m;
          mn = m + delta / longint'(n);
          d2 = x - mn;
          mean_tab[idx] = mn;
          ssq_tab[idx] = add_sat(ssq_tab[idx],
                                 mul_floor32(magnitude(delta), magnitude(d2)));
        end
        MODE_END_CELL: begin
          if (!e.missing && cells[e.blk] != 32'hFFFF_FFFF) cells[e.blk]++;
        end
        MODE_REPORT: begin
          r = '{default: 0};
          c = cells[e.blk];
          if (c != 0) begin
            m = mean_tab[idx];
            s = ssq_tab[idx];
            z = nz_tab[idx];
            if (z > c) z = c;
            if (keeps_zeros()) begin
              mg = magnitude(m);
              t = scale(mul_floor32(mg, mg), z, c);
              p = {64'd0, t} * {64'd0, c - z};
              s = (p[127:64] != 0) ? '1 : add_sat(s, p[63:0]);
              mg = scale(mg, z, c);
              m = (m < 0) ? -longint'(mg) : longint'(mg);
            end
            r.mean = m[47:0];
            r.mean_ok = 1'b1;
            if (c > 1) begin
              s = s / (c - 1);
              r.variance = (s > {1'b0, VAR_MAX}) ? VAR_MAX : s[62:0];
              r.variance_ok = 1'b1;
            end
          end
          pending_reports.push_back(r);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string field, bit [63:0] got, bit [63:0] want);
      $display("mismatch on %s: got %h, expected %h", field, got, want);
      errors++;
    endtask

    task check_result(stats_t got);
      stats_t want;
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected result", got.mean, 0);
        return;
      end
      want = pending_reports.pop_front();
      if (got.mean != want.mean) report_mismatch("mean_value", got.mean, want.mean);
      if (got.variance != want.variance)
        report_mismatch("variance_value", got.variance, want.variance);
      if (got.mean_ok != want.mean_ok)
        report_mismatch("mean_valid", got.mean_ok, want.mean_ok);
      if (got.variance_ok != want.variance_ok)
        report_mismatch("variance_valid", got.variance_ok, want.variance_ok);
    endtask

    function int outstanding();
      return pending_reports.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic               cfg_index;
  logic [31:0]        cfg_data;
  logic               item_valid;
  logic               item_stall;
  logic [1:0]         mode;
  logic [11:0]        gene_index;
  logic [3:0]         block_index;
  logic               block_missing;
  logic [31:0]        raw_value;
  logic [23:0]        size_factor;
  logic               result_valid;
  logic               result_stall;
  logic signed [47:0] mean_value;
  logic [62:0]        variance_value;
  logic               mean_valid;
  logic               variance_valid;

  welford_scoreboard stats_board;

  int sent_count;      // accepted input transactions so far
  int send_idle_pct;   // chance in percent that the sender idles a cycle
  int recv_idle_pct;   // chance in percent that the receiver stalls a cycle
  int hold_cycles;     // remaining cycles of a long receiver hold-off

  blocked_welford_mean_variance DUT (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit, far beyond the slowest correct run including the clearing pass.
  initial begin
    #3_000_000;
    $display("blocked_welford_mean_variance test failed");
    $finish;
  end

  // Receiver side: random stalls, or a long counted hold-off when requested.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      result_stall = 1'b1;
      hold_cycles--;
    end else begin
      result_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Every accepted result transaction goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      stats_board.check_result('{mean_value, variance_value, mean_valid, variance_valid});
  end

  task automatic write_register(bit idx, bit [31:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    stats_board.write_config(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Waits until every report has come back, then lets the block drain any
  // value item that is still in flight (those produce no result).
  task automatic drain();
    while (stats_board.outstanding() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // Drives one transaction; inputs move on the falling edge only.
  task automatic send_item(entry_t e);
    if (sent_count < 150) begin
      send_idle_pct = 15;
      recv_idle_pct = 61;
    end else if (sent_count < 300) begin
      send_idle_pct = 61;
      recv_idle_pct = 15;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid    = 1'b1;
    mode          = e.mode;
    gene_index    = e.gene;
    block_index   = e.blk;
    block_missing = e.missing;
    raw_value     = e.raw;
    size_factor   = e.sf;
    do @(posedge clk); while (item_stall);
    stats_board.note_item(e);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_fields(bit [1:0] md, bit [11:0] g, bit [3:0] b, bit miss,
                             bit [31:0] raw, bit [23:0] sf);
    entry_t e;
    e = '{md, g, b, miss, raw, sf};
    send_item(e);
  endtask

  function automatic bit [31:0] pick_raw();
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) return 0;
    if (sel < 70) return $urandom_range(65280);
    if (sel < 90) return $urandom;
    return 32'h0080_0000 + $urandom_range(512) - 256;
  endfunction

  function automatic bit [23:0] pick_size_factor();
    if ($urandom_range(99) < 75) return $urandom_range(262143, 16384);
    return $urandom;
  endfunction

  // A block of random traffic under the current settings. Most of it is
  // well-formed cells (values of one cell, then its end-of-cell marker) with
  // reports in between; the rest is noise over the full field ranges.
  task automatic random_traffic(int count);
    int target;
    int values;
    bit [3:0]  b;
    bit        miss;
    bit [23:0] sf;
    entry_t    e;
    target = sent_count + count;
    while (sent_count < target) begin
      case ($urandom_range(9))
        0: begin
          e.mode    = $urandom;
          e.gene    = $urandom;
          e.blk     = $urandom;
          e.missing = $urandom;
          e.raw     = $urandom;
          e.sf      = $urandom;
          send_item(e);
        end
        1, 2, 3: send_fields(MODE_REPORT, $urandom_range(7), $urandom_range(5), $urandom,
                             $urandom, $urandom);
        default: begin
          b = $urandom_range(5);
          miss = ($urandom_range(9) == 0);
          sf = pick_size_factor();
          values = $urandom_range(6, 1);
          for (int i = 0; i < values; i++)
            send_fields(MODE_VALUE, $urandom_range(7), b, miss, pick_raw(), sf);
          send_fields(MODE_END_CELL, $urandom, b, miss, $urandom, $urandom);
        end
      endcase
    end
  endtask

  // A few boundary values at the start of each setting.
  task automatic boundary_items();
    send_fields(MODE_VALUE, 12'd1, 4'd2, 1'b0, 32'd0, 24'h01_0000);
    send_fields(MODE_VALUE, 12'd1, 4'd2, 1'b0, 32'hFFFF_FFFF, 24'd0);
    send_fields(MODE_VALUE, 12'd1, 4'd2, 1'b0, 32'h0000_0100, 24'hFF_FFFF);
    send_fields(MODE_VALUE, 12'd1, 4'd2, 1'b0, 32'h0000_0001, 24'd0);
    send_fields(MODE_END_CELL, 12'd0, 4'd2, 1'b0, 32'd0, 24'd1);
    send_fields(MODE_REPORT, 12'd1, 4'd2, 1'b0, 32'd0, 24'd1);
  endtask

  initial begin
    bit [1:0]  mode_list[8];
    bit [31:0] pseudo_list[8];
    stats_board   = new();
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = CFG_TRANSFORM_MODE;
    cfg_data      = '0;
    item_valid    = 1'b0;
    mode          = MODE_VALUE;
    gene_index    = '0;
    block_index   = '0;
    block_missing = 1'b0;
    raw_value     = '0;
    size_factor   = '0;
    result_stall  = 1'b0;
    sent_count    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part under the reset settings (raw values, zeros preserved).
    // A report of a block with no cells yet gives invalid statistics.
    send_fields(MODE_REPORT, 12'd0, 4'd5, 1'b0, 32'd0, 24'd0);
    send_fields(MODE_VALUE, 12'd0, 4'd5, 1'b0, 32'h0000_0300, 24'h01_0000);
    send_fields(MODE_VALUE, 12'd0, 4'd5, 1'b1, 32'h0000_0500, 24'h01_0000);
    send_fields(MODE_VALUE, 12'hFFF, 4'hF, 1'b0, 32'h007F_FFFF, 24'hFF_FFFF);
    send_fields(MODE_VALUE, 12'hFFF, 4'hF, 1'b0, 32'hFFFF_FFFF, 24'h00_0001);
    send_fields(MODE_VALUE, 12'd0, 4'd5, 1'b0, 32'd0, 24'h01_0000);
    // An end of cell with a missing block is ignored.
    send_fields(MODE_END_CELL, 12'd0, 4'd5, 1'b1, 32'd0, 24'd0);
    send_fields(MODE_END_CELL, 12'd0, 4'd5, 1'b0, 32'd0, 24'd0);
    // One cell: the mean is valid, the variance is not.
    send_fields(MODE_REPORT, 12'd0, 4'd5, 1'b1, 32'd0, 24'd0);
    send_fields(MODE_END_CELL, 12'd0, 4'd5, 1'b0, 32'd0, 24'd0);
    send_fields(MODE_END_CELL, 12'd0, 4'd5, 1'b0, 32'd0, 24'd0);
    send_fields(MODE_END_CELL, 12'd0, 4'hF, 1'b0, 32'd0, 24'd0);
    // Zero correction with nonzeros fewer than cells, then with nonzeros more than cells.
    send_fields(MODE_REPORT, 12'd0, 4'd5, 1'b0, 32'd0, 24'd0);
    send_fields(MODE_REPORT, 12'hFFF, 4'hF, 1'b0, 32'hFFFF_FFFF, 24'hFF_FFFF);
    // A mode-three item is ignored and gives no result.
    send_fields(2'd3, 12'd0, 4'd5, 1'b0, 32'h0000_0100, 24'h01_0000);
    send_fields(MODE_REPORT, 12'd0, 4'd5, 1'b0, 32'd0, 24'd0);

    // Settings visited in turn: each transform, the pseudo count at one, zero,
    // its maximum, a random value and one and a half, and the unused mode three.
    mode_list   = '{TM_RAW, TM_DIV, TM_LOG, TM_LOG, TM_LOG, 2'd3, TM_LOG, TM_DIV};
    pseudo_list = '{PSEUDO_ONE, PSEUDO_ONE, PSEUDO_ONE, 32'd0, 32'hFFFF_FFFF,
                    PSEUDO_ONE, $urandom, 32'h0001_8000};
    for (int ph = 0; ph < 8; ph++) begin
      item_valid = 1'b0;
      drain();
      write_register(CFG_TRANSFORM_MODE, {30'd0, mode_list[ph]});
      write_register(CFG_PSEUDO_COUNT, pseudo_list[ph]);
      boundary_items();
      // Long receiver hold-off while the sender keeps offering transactions,
      // so the block backs up and stalls its input.
      if (ph == 2) hold_cycles = 3000;
      random_traffic(25);
      // Sender pauses until every outstanding report has been returned.
      if (ph == 4) begin
        item_valid = 1'b0;
        while (stats_board.outstanding() != 0) @(negedge clk);
      end
      random_traffic(25);
    end

    item_valid = 1'b0;
    drain();
    if (stats_board.errors == 0) begin
      $display("blocked_welford_mean_variance test passed");
    end else begin
      $display("blocked_welford_mean_variance test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/bwmv_pkg.sv
rtl/bwmv_ram.sv
rtl/bwmv_div.sv
rtl/bwmv_mul.sv
rtl/blocked_welford_mean_variance.sv
verif/tb_blocked_welford_mean_variance.sv
